>>> rtl/lbmw_pkg.sv
package lbmw_pkg;

	localparam int DATA_W = 32;
	localparam int NUM_DIRS = 5;

	localparam int DIR_REST = 0;
	localparam int DIR_EAST = 1;
	localparam int DIR_NORTH = 2;
	localparam int DIR_WEST = 3;
	localparam int DIR_SOUTH = 4;

	localparam int RELAX_W = 18;
	localparam int SPEED_W = 17;
	localparam int C2_W = 18;
	localparam int COEF0_W = 21;
	localparam int RHO2_W = 37;
	localparam int MOM_W = 33;

	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int ONE_Q16 = 65536;

	localparam logic REG_RELAX = 1'b0;
	localparam logic REG_SPEED = 1'b1;

	localparam logic [RELAX_W-1:0] RELAX_RESET = 18'd131072;
	localparam logic [SPEED_W-1:0] SPEED_RESET = 17'd32768;
	localparam logic [C2_W-1:0] C2_RESET = 18'd16384;
	localparam logic signed [COEF0_W-1:0] COEF0_RESET = 21'sd32768;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		word_t [NUM_DIRS-1:0] dirs;
		logic signed [RHO2_W-1:0] rho2;
		logic signed [MOM_W-1:0] jx;
		logic signed [MOM_W-1:0] jy;
	} cell_t;

	typedef struct packed {
		logic [RELAX_W-1:0] relax;
		logic [C2_W-1:0] c2;
		logic signed [COEF0_W-1:0] coef0;
	} coef_t;

endpackage

>>> rtl/lbmw_regs.sv
module lbmw_regs import lbmw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output coef_t                 coef
);

	logic                      wr;
	logic [2*SPEED_W:0]        speed_sq;
	logic [C2_W-1:0]           c2_new;
	logic signed [COEF0_W-1:0] coef0_new;
	logic [RELAX_W-1:0]        relax_q;
	logic [SPEED_W-1:0]        speed_q;
	logic [C2_W-1:0]           c2_q;
	logic signed [COEF0_W-1:0] coef0_q;

	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	// squared speed rounded half up, and rest coefficient 1 - 2*c^2
	always_comb begin
		speed_sq = (2*SPEED_W+1)'(pwdata[SPEED_W-1:0]) * (2*SPEED_W+1)'(pwdata[SPEED_W-1:0]);
		speed_sq = speed_sq + (2*SPEED_W+1)'(ONE_Q16 / 2);
		c2_new = speed_sq[C2_W+15:16];
		coef0_new = COEF0_W'(ONE_Q16) - $signed({2'b00, c2_new, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= RELAX_RESET;
			speed_q <= SPEED_RESET;
			c2_q <= C2_RESET;
			coef0_q <= COEF0_RESET;
		end else if (wr) begin
			unique case (paddr[2])
				REG_RELAX: begin
					relax_q <= pwdata[RELAX_W-1:0];
				end
				REG_SPEED: begin
					speed_q <= pwdata[SPEED_W-1:0];
					c2_q <= c2_new;
					coef0_q <= coef0_new;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RELAX: prdata = CFG_DATA_W'(relax_q);
			REG_SPEED: prdata = CFG_DATA_W'(speed_q);
			default:   prdata = '0;
		endcase
	end

	assign coef.relax = relax_q;
	assign coef.c2 = c2_q;
	assign coef.coef0 = coef0_q;

	a_coef0_tracks_c2: assert property (@(posedge clk) disable iff (!arst_n)
		coef0_q == COEF0_W'(ONE_Q16) - $signed({2'b00, c2_q, 1'b0}))
		else $error("rest coefficient out of step with squared speed");

endmodule

>>> rtl/lbmw_front.sv
module lbmw_front import lbmw_pkg::*; (
	input  logic                     cell_valid,
	output logic                     cell_ready,
	input  logic signed [DATA_W-1:0] dist_rest,
	input  logic signed [DATA_W-1:0] dist_east,
	input  logic signed [DATA_W-1:0] dist_north,
	input  logic signed [DATA_W-1:0] dist_west,
	input  logic signed [DATA_W-1:0] dist_south,
	input  logic signed [DATA_W-1:0] source_term,
	input  logic                     full,
	output logic                     push,
	output cell_t                    entry
);

	logic signed [DATA_W+2:0] sum5;

	assign cell_ready = !full;
	assign push = cell_valid && !full;

	// doubled density plus source term, and momenta, exact
	always_comb begin
		sum5 = (DATA_W+3)'(dist_rest) + (DATA_W+3)'(dist_east) + (DATA_W+3)'(dist_north)
			+ (DATA_W+3)'(dist_west) + (DATA_W+3)'(dist_south);
		entry.dirs[DIR_REST] = dist_rest;
		entry.dirs[DIR_EAST] = dist_east;
		entry.dirs[DIR_NORTH] = dist_north;
		entry.dirs[DIR_WEST] = dist_west;
		entry.dirs[DIR_SOUTH] = dist_south;
		entry.rho2 = (RHO2_W'(sum5) <<< 1) + RHO2_W'(source_term);
		entry.jx = MOM_W'(dist_east) - MOM_W'(dist_west);
		entry.jy = MOM_W'(dist_north) - MOM_W'(dist_south);
	end

endmodule

>>> rtl/lbmw_queue.sv
module lbmw_queue import lbmw_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cell_t wdata,
	input  logic  pop,
	output cell_t rdata,
	output logic  full,
	output logic  not_empty
);

	localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cell_t            entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign rdata = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != CNT_W'(DEPTH))
		else $error("queue written while full");

endmodule

>>> rtl/lbmw_back.sv
module lbmw_back import lbmw_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  cell_t                    entry,
	input  coef_t                    coef,
	output logic                     pop,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [DATA_W-1:0] new_rest,
	output logic signed [DATA_W-1:0] new_east,
	output logic signed [DATA_W-1:0] new_north,
	output logic signed [DATA_W-1:0] new_west,
	output logic signed [DATA_W-1:0] new_south
);

	localparam int RHO_LO_W = 18;
	localparam int RHO_HI_W = RHO2_W - RHO_LO_W;
	localparam int PP0_W = RHO_HI_W + COEF0_W;
	localparam int PB_W = RHO_HI_W + C2_W + 1;
	localparam int P0_W = PP0_W + RHO_LO_W;
	localparam int BASE_W = PB_W + RHO_LO_W;
	localparam int ACC_W = 60;
	localparam int D_W = 41;
	localparam int D_LO_W = 20;
	localparam int PR_W = (D_W - D_LO_W) + RELAX_W + 1;
	localparam int SUM_W = 62;
	localparam int V_W = SUM_W - 16;

	localparam logic signed [ACC_W-1:0] RND_REST = ACC_W'(1) <<< 16;
	localparam logic signed [ACC_W-1:0] RND_DIR = ACC_W'(1) <<< 17;
	localparam logic signed [SUM_W-1:0] RND_OUT = SUM_W'(1) <<< 15;
	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [DATA_W-1:0] f_s1 [NUM_DIRS];
	logic signed [DATA_W-1:0] f_s2 [NUM_DIRS];
	logic signed [DATA_W-1:0] f_s3 [NUM_DIRS];
	logic signed [DATA_W-1:0] f_s4 [NUM_DIRS];
	logic signed [MOM_W-1:0]  jx_s1, jy_s1, jx_s2, jy_s2;
	logic signed [PP0_W-1:0]  pp0_hi_s1, pp0_lo_s1;
	logic signed [PB_W-1:0]   pb_hi_s1, pb_lo_s1;
	logic signed [P0_W-1:0]   p0_s2;
	logic signed [BASE_W-1:0] base_s2;
	logic signed [D_W-1:0]    d_s3 [NUM_DIRS];
	logic signed [PR_W-1:0]   pr_hi_s4 [NUM_DIRS];
	logic signed [PR_W-1:0]   pr_lo_s4 [NUM_DIRS];
	logic signed [DATA_W-1:0] out_s5 [NUM_DIRS];

	logic signed [RHO_HI_W-1:0] rho_hi;
	logic signed [RHO_LO_W:0]   rho_lo;
	logic signed [C2_W:0]       c2_s;
	logic signed [RELAX_W:0]    r_s;
	logic signed [PP0_W-1:0]    pp0_hi_d, pp0_lo_d;
	logic signed [PB_W-1:0]     pb_hi_d, pb_lo_d;
	logic signed [ACC_W-1:0]    t_d [NUM_DIRS];
	logic signed [D_W-1:0]      d_d [NUM_DIRS];
	logic signed [PR_W-1:0]     pr_hi_d [NUM_DIRS];
	logic signed [PR_W-1:0]     pr_lo_d [NUM_DIRS];
	logic signed [SUM_W-1:0]    acc_d [NUM_DIRS];
	logic signed [V_W-1:0]      v_d [NUM_DIRS];
	logic signed [DATA_W-1:0]   out_d [NUM_DIRS];

	assign en = !v_s5 || result_ready;
	assign pop = q_valid && en;

	// equilibrium partial products
	always_comb begin
		rho_hi = entry.rho2[RHO2_W-1:RHO_LO_W];
		rho_lo = $signed({1'b0, entry.rho2[RHO_LO_W-1:0]});
		c2_s = $signed({1'b0, coef.c2});
		pp0_hi_d = rho_hi * coef.coef0;
		pp0_lo_d = rho_lo * coef.coef0;
		pb_hi_d = rho_hi * c2_s;
		pb_lo_d = rho_lo * c2_s;
	end

	// feq - f per lane, rounded half up
	always_comb begin
		for (int k = 0; k < NUM_DIRS; k++) begin
			if (k == DIR_REST) begin
				t_d[k] = ACC_W'(p0_s2) - (ACC_W'(f_s2[k]) <<< 17) + RND_REST;
				d_d[k] = t_d[k][D_W+16:17];
			end else begin
				t_d[k] = ACC_W'(base_s2) - (ACC_W'(f_s2[k]) <<< 18) + RND_DIR;
				if (k == DIR_EAST) begin
					t_d[k] = t_d[k] + (ACC_W'(jx_s2) <<< 17);
				end else if (k == DIR_WEST) begin
					t_d[k] = t_d[k] - (ACC_W'(jx_s2) <<< 17);
				end else if (k == DIR_NORTH) begin
					t_d[k] = t_d[k] + (ACC_W'(jy_s2) <<< 17);
				end else begin
					t_d[k] = t_d[k] - (ACC_W'(jy_s2) <<< 17);
				end
				d_d[k] = t_d[k][D_W+17:18];
			end
		end
	end

	// relaxation partial products
	always_comb begin
		r_s = $signed({1'b0, coef.relax});
		for (int k = 0; k < NUM_DIRS; k++) begin
			pr_hi_d[k] = $signed(d_s3[k][D_W-1:D_LO_W]) * r_s;
			pr_lo_d[k] = $signed({1'b0, d_s3[k][D_LO_W-1:0]}) * r_s;
		end
	end

	// f + round(r*(feq-f)), saturated
	always_comb begin
		for (int k = 0; k < NUM_DIRS; k++) begin
			acc_d[k] = (SUM_W'(pr_hi_s4[k]) <<< D_LO_W) + SUM_W'(pr_lo_s4[k])
				+ (SUM_W'(f_s4[k]) <<< 16) + RND_OUT;
			v_d[k] = acc_d[k][SUM_W-1:16];
			if (v_d[k][V_W-1:DATA_W-1] == {(V_W-DATA_W+1){v_d[k][V_W-1]}}) begin
				out_d[k] = v_d[k][DATA_W-1:0];
			end else begin
				out_d[k] = v_d[k][V_W-1] ? SAT_MIN : SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_DIRS; k++) begin
				f_s1[k] <= $signed(entry.dirs[k]);
				f_s2[k] <= f_s1[k];
				f_s3[k] <= f_s2[k];
				f_s4[k] <= f_s3[k];
				d_s3[k] <= d_d[k];
				pr_hi_s4[k] <= pr_hi_d[k];
				pr_lo_s4[k] <= pr_lo_d[k];
				out_s5[k] <= out_d[k];
			end
			jx_s1 <= entry.jx;
			jy_s1 <= entry.jy;
			jx_s2 <= jx_s1;
			jy_s2 <= jy_s1;
			pp0_hi_s1 <= pp0_hi_d;
			pp0_lo_s1 <= pp0_lo_d;
			pb_hi_s1 <= pb_hi_d;
			pb_lo_s1 <= pb_lo_d;
			p0_s2 <= (P0_W'(pp0_hi_s1) <<< RHO_LO_W) + P0_W'(pp0_lo_s1);
			base_s2 <= (BASE_W'(pb_hi_s1) <<< RHO_LO_W) + BASE_W'(pb_lo_s1);
		end
	end

	assign result_valid = v_s5;
	assign new_rest = out_s5[DIR_REST];
	assign new_east = out_s5[DIR_EAST];
	assign new_north = out_s5[DIR_NORTH];
	assign new_west = out_s5[DIR_WEST];
	assign new_south = out_s5[DIR_SOUTH];

	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped request did not enter the pipeline");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !result_ready) |=> ($stable({v_s1, v_s2, v_s3, v_s4}) && v_s5))
		else $error("pipeline moved during output stall");

endmodule

>>> rtl/lbm_d2q5_wave_collision.sv
// D2Q5 wave-equation BGK collision, one lattice cell per request. Each request carries the five
// distributions and a source term in signed Q15.16 (the arithmetic is linear in the data, so any
// fixed-point format passes through unchanged) and yields one result with the five relaxed,
// saturated distributions f + r*(feq - f). A front stage forms doubled density (plus the source
// term) and the two momenta and writes them into a CELL_QUEUE_DEPTH-entry queue; a five-stage
// back pipeline of split multipliers forms the equilibria and the relaxation. The block sustains
// one cell per clock cycle while result_ready is high or no result is waiting; the queue absorbs
// output stalls so the input keeps accepting until it fills. Registers: relax_factor at byte
// address 0 (unsigned Q2.16, reset 2.0) and wave_speed at byte address 4 (unsigned Q1.16,
// reset 0.5); write them only while no request is in flight.
module lbm_d2q5_wave_collision import lbmw_pkg::*; #(
	parameter int CELL_QUEUE_DEPTH = QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_W-1:0]    paddr,
	input  logic [CFG_DATA_W-1:0]    pwdata,
	output logic [CFG_DATA_W-1:0]    prdata,
	output logic                     pready,
	input  logic                     cell_valid,
	output logic                     cell_ready,
	input  logic signed [DATA_W-1:0] dist_rest,
	input  logic signed [DATA_W-1:0] dist_east,
	input  logic signed [DATA_W-1:0] dist_north,
	input  logic signed [DATA_W-1:0] dist_west,
	input  logic signed [DATA_W-1:0] dist_south,
	input  logic signed [DATA_W-1:0] source_term,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [DATA_W-1:0] new_rest,
	output logic signed [DATA_W-1:0] new_east,
	output logic signed [DATA_W-1:0] new_north,
	output logic signed [DATA_W-1:0] new_west,
	output logic signed [DATA_W-1:0] new_south
);

	coef_t coef;
	cell_t push_entry;
	cell_t pop_entry;
	logic  push;
	logic  pop;
	logic  full;
	logic  not_empty;

	lbmw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	lbmw_front u_front (
		.cell_valid  (cell_valid),
		.cell_ready  (cell_ready),
		.dist_rest   (dist_rest),
		.dist_east   (dist_east),
		.dist_north  (dist_north),
		.dist_west   (dist_west),
		.dist_south  (dist_south),
		.source_term (source_term),
		.full        (full),
		.push        (push),
		.entry       (push_entry)
	);

	lbmw_queue #(
		.DEPTH (CELL_QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_entry),
		.pop       (pop),
		.rdata     (pop_entry),
		.full      (full),
		.not_empty (not_empty)
	);

	lbmw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (not_empty),
		.entry        (pop_entry),
		.coef         (coef),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.new_rest     (new_rest),
		.new_east     (new_east),
		.new_north    (new_north),
		.new_west     (new_west),
		.new_south    (new_south)
	);

endmodule
